// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL.
// Depends on nothing; included by files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold whenever the antecedent holds (same cycle).
`define MTS_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Expression must hold at every clock edge outside reset.
`define MTS_ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");

`endif

// ===== rtl/mts_pkg.sv =====
// Package for the minimum-tracking stack: sizes, codes, sequencer states.
// No dependencies; used by every RTL module of the block.
`default_nettype none

package mts_pkg;

  localparam int DEPTH  = 128;
  localparam int DATA_W = 32;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);

  typedef enum logic {
    CMD_PUSH = 1'b0,
    CMD_POP  = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ERR_OK    = 2'd0,
    ERR_FULL  = 2'd1,
    ERR_EMPTY = 2'd2
  } err_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_TOP,
    ST_SCAN,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    MIN_HOLD,
    MIN_LOAD,
    MIN_TRY,
    MIN_CLEAR
  } min_op_e;

  typedef struct packed {
    min_op_e             op;
    logic [ADDR_W-1:0]   idx;
  } min_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/min_tracking_stack.sv =====
// Top level of the minimum-tracking stack: sequencer, datapath, result register.
// Depends on mts_pkg, mts_mem, mts_min_unit and assert_macros.svh.
//
// Input channel (in_valid_i/in_ready_o): one transaction per operation,
//   cmd_i = 0 pushes value_i, cmd_i = 1 pops the top entry.
// Output channel (out_valid_o/out_ready_i): exactly one result per
//   transaction: top, minimum, count, empty flag, error code. An empty stack
//   reports top and minimum as 0. Push on full (128 entries) gives error 1,
//   pop on empty error 2; both leave the stack untouched.
// Sequence (states from the accept to the result register):
//   push, dropped op, pop down to empty: EXEC, DONE; other pop: EXEC, TOP,
//   DONE; pop that removes the minimum: EXEC, TOP, then SCAN for each of the
//   N entries left (up to 127), one entry per cycle through the single read
//   port into the shared comparator, then DONE. in_ready_o is high only while
//   idle, so a new transaction is taken only after the result is offered.
// Stall: one result is held in the output register; the next transaction is
//   accepted and then waits in its final step until the receiver takes it.
// Reset: asynchronous, active low; stack empty, minimum index 0, no result
//   pending. Memory contents are not cleared (never read before written).
`default_nettype none

module min_tracking_stack (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic                              cmd_i,
  input  wire logic signed [mts_pkg::DATA_W-1:0] value_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic signed [mts_pkg::DATA_W-1:0]      top_value_o,
  output logic signed [mts_pkg::DATA_W-1:0]      min_value_o,
  output logic [mts_pkg::CNT_W-1:0]              count_o,
  output logic                                   empty_res_o,
  output logic [1:0]                             error_code_o
);

  localparam logic [mts_pkg::CNT_W-1:0] FULL_CNT = mts_pkg::CNT_W'(mts_pkg::DEPTH);

  mts_pkg::state_e state_q, state_d;

  // latched transaction
  mts_pkg::cmd_e                     cmd_q, cmd_d;
  logic signed [mts_pkg::DATA_W-1:0] val_q, val_d;

  // stack state
  logic [mts_pkg::CNT_W-1:0]         count_q, count_d;
  logic signed [mts_pkg::DATA_W-1:0] top_q, top_d;
  logic                              rescan_q, rescan_d;
  logic [mts_pkg::CNT_W-1:0]         scan_q, scan_d;   // next address to read
  mts_pkg::err_e                     err_q, err_d;

  // result register
  logic                              out_valid_q, out_valid_d;
  logic signed [mts_pkg::DATA_W-1:0] out_top_q, out_min_q;
  logic [mts_pkg::CNT_W-1:0]         out_cnt_q;
  logic [1:0]                        out_err_q;

  // memory / min unit hookup
  logic                              mem_we;
  logic [mts_pkg::ADDR_W-1:0]        mem_waddr, mem_raddr;
  logic signed [mts_pkg::DATA_W-1:0] mem_rdata;
  mts_pkg::min_ctl_t                 min_ctl;
  logic signed [mts_pkg::DATA_W-1:0] min_cand;
  logic signed [mts_pkg::DATA_W-1:0] min_val;
  logic [mts_pkg::ADDR_W-1:0]        min_idx;

  logic in_fire, out_free;

  assign in_ready_o = (state_q == mts_pkg::ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  mts_mem u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (val_q),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  mts_min_unit u_min (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (min_ctl),
    .cand_i    (min_cand),
    .min_val_o (min_val),
    .min_idx_o (min_idx)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mts_pkg::ST_IDLE: begin
        if (in_fire) state_d = mts_pkg::ST_EXEC;
      end
      mts_pkg::ST_EXEC: begin
        if (cmd_q == mts_pkg::CMD_PUSH || count_q <= mts_pkg::CNT_W'(1)) begin
          state_d = mts_pkg::ST_DONE;
        end else begin
          state_d = mts_pkg::ST_TOP;
        end
      end
      mts_pkg::ST_TOP: begin
        state_d = rescan_q ? mts_pkg::ST_SCAN : mts_pkg::ST_DONE;
      end
      mts_pkg::ST_SCAN: begin
        if (scan_q == count_q) state_d = mts_pkg::ST_DONE;
      end
      mts_pkg::ST_DONE: begin
        if (out_free) state_d = mts_pkg::ST_IDLE;
      end
      default: state_d = mts_pkg::ST_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    cmd_d       = cmd_q;
    val_d       = val_q;
    count_d     = count_q;
    top_d       = top_q;
    rescan_d    = rescan_q;
    scan_d      = scan_q;
    err_d       = err_q;
    out_valid_d = out_valid_q && !out_ready_i;
    mem_we      = 1'b0;
    mem_waddr   = count_q[mts_pkg::ADDR_W-1:0];
    mem_raddr   = '0;
    min_ctl     = '{op: mts_pkg::MIN_HOLD, idx: '0};
    min_cand    = val_q;

    unique case (state_q)
      mts_pkg::ST_IDLE: begin
        if (in_fire) begin
          cmd_d = mts_pkg::cmd_e'(cmd_i);
          val_d = value_i;
        end
      end
      mts_pkg::ST_EXEC: begin
        err_d    = mts_pkg::ERR_OK;
        rescan_d = 1'b0;
        if (cmd_q == mts_pkg::CMD_PUSH) begin
          if (count_q == FULL_CNT) begin
            err_d = mts_pkg::ERR_FULL;
          end else begin
            mem_we      = 1'b1;
            count_d     = count_q + 1'b1;
            top_d       = val_q;
            min_ctl.idx = count_q[mts_pkg::ADDR_W-1:0];
            min_ctl.op  = (count_q == '0) ? mts_pkg::MIN_LOAD : mts_pkg::MIN_TRY;
          end
        end else begin
          if (count_q == '0) begin
            err_d = mts_pkg::ERR_EMPTY;
          end else begin
            count_d   = count_q - 1'b1;
            // new top sits two below the old count
            mem_raddr = mts_pkg::ADDR_W'(count_q - mts_pkg::CNT_W'(2));
            rescan_d  = ({1'b0, min_idx} == count_q - 1'b1);
            if (count_q == mts_pkg::CNT_W'(1)) begin
              top_d      = '0;
              min_ctl.op = mts_pkg::MIN_CLEAR;
            end
          end
        end
      end
      mts_pkg::ST_TOP: begin
        top_d     = mem_rdata;
        mem_raddr = '0;
        scan_d    = mts_pkg::CNT_W'(1);
      end
      mts_pkg::ST_SCAN: begin
        // read data is the entry at scan_q - 1
        min_cand    = mem_rdata;
        min_ctl.idx = mts_pkg::ADDR_W'(scan_q - 1'b1);
        min_ctl.op  = (scan_q == mts_pkg::CNT_W'(1)) ? mts_pkg::MIN_LOAD
                                                     : mts_pkg::MIN_TRY;
        mem_raddr   = scan_q[mts_pkg::ADDR_W-1:0];
        scan_d      = scan_q + 1'b1;
      end
      mts_pkg::ST_DONE: begin
        if (out_free) out_valid_d = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mts_pkg::ST_IDLE;
      count_q     <= '0;
      rescan_q    <= 1'b0;
      scan_q      <= '0;
      err_q       <= mts_pkg::ERR_OK;
      out_valid_q <= 1'b0;
      cmd_q       <= mts_pkg::CMD_PUSH;
      top_q       <= '0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rescan_q    <= rescan_d;
      scan_q      <= scan_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
      cmd_q       <= cmd_d;
      top_q       <= top_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    if (state_q == mts_pkg::ST_DONE && out_free) begin
      out_top_q <= top_q;
      out_min_q <= (count_q == '0) ? '0 : min_val;
      out_cnt_q <= count_q;
      out_err_q <= err_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign top_value_o  = out_top_q;
  assign min_value_o  = out_min_q;
  assign count_o      = out_cnt_q;
  assign empty_res_o  = (out_cnt_q == '0);
  assign error_code_o = out_err_q;

  `include "assert_macros.svh"

  `MTS_ASSERT_ALWAYS(a_count_bound, clk_i, rst_ni, count_q <= FULL_CNT)
  `MTS_ASSERT_IMPLY(a_min_idx_live, clk_i, rst_ni,
    state_q == mts_pkg::ST_IDLE && count_q != '0, {1'b0, min_idx} < count_q)
  `MTS_ASSERT_IMPLY(a_empty_zero, clk_i, rst_ni, out_valid_o && empty_res_o,
    top_value_o == '0 && min_value_o == '0)
  `MTS_ASSERT_IMPLY(a_min_le_top, clk_i, rst_ni, out_valid_o && !empty_res_o,
    min_value_o <= top_value_o)

endmodule

`default_nettype wire

// ===== rtl/mts_mem.sv =====
// Stack storage: one write port, one read port with registered read data.
// Depends on mts_pkg.
`default_nettype none

module mts_mem (
  input  wire logic                              clk_i,
  input  wire logic                              we_i,
  input  wire logic [mts_pkg::ADDR_W-1:0]        waddr_i,
  input  wire logic signed [mts_pkg::DATA_W-1:0] wdata_i,
  input  wire logic [mts_pkg::ADDR_W-1:0]        raddr_i,
  output logic signed [mts_pkg::DATA_W-1:0]      rdata_o
);

  logic signed [mts_pkg::DATA_W-1:0] mem_q [mts_pkg::DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== rtl/mts_min_unit.sv =====
// Minimum tracker: one shared signed comparator plus the minimum value/index.
// Depends on mts_pkg.
`default_nettype none

module mts_min_unit (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire mts_pkg::min_ctl_t                 ctl_i,
  input  wire logic signed [mts_pkg::DATA_W-1:0] cand_i,
  output logic signed [mts_pkg::DATA_W-1:0]      min_val_o,
  output logic [mts_pkg::ADDR_W-1:0]             min_idx_o
);

  logic signed [mts_pkg::DATA_W-1:0] min_val_q, min_val_d;
  logic [mts_pkg::ADDR_W-1:0]        min_idx_q, min_idx_d;
  logic                              less;

  // strict less: ties keep the older (lower) index
  assign less = cand_i < min_val_q;

  always_comb begin
    min_val_d = min_val_q;
    min_idx_d = min_idx_q;
    unique case (ctl_i.op)
      mts_pkg::MIN_HOLD: ;
      mts_pkg::MIN_LOAD: begin
        min_val_d = cand_i;
        min_idx_d = ctl_i.idx;
      end
      mts_pkg::MIN_TRY: begin
        if (less) begin
          min_val_d = cand_i;
          min_idx_d = ctl_i.idx;
        end
      end
      mts_pkg::MIN_CLEAR: begin
        min_val_d = '0;
        min_idx_d = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_val_q <= '0;
      min_idx_q <= '0;
    end else begin
      min_val_q <= min_val_d;
      min_idx_q <= min_idx_d;
    end
  end

  assign min_val_o = min_val_q;
  assign min_idx_o = min_idx_q;

endmodule

`default_nettype wire

// ===== bench/min_tracking_stack_test.sv =====
// Self-checking bench for min_tracking_stack: random and directed push/pop traffic
// over valid/ready, predicted by an in-bench stack mirror. Depends on mts_pkg.
`default_nettype none

module min_tracking_stack_test;

  // Traffic pacing: which side of the bench inserts gaps.
  typedef enum int {
    PACE_STEADY,
    PACE_SEND_GAPS,
    PACE_RECV_STALLS,
    PACE_BOTH_GAPS
  } pace_e;

  // One input transaction waiting to be driven.
  typedef struct {
    mts_pkg::cmd_e                     op;
    logic signed [mts_pkg::DATA_W-1:0] val;
    pace_e                             pace;
  } stack_op_t;

  // What the stack should report after one transaction.
  typedef struct {
    logic signed [mts_pkg::DATA_W-1:0] top;
    logic signed [mts_pkg::DATA_W-1:0] low;
    logic [mts_pkg::CNT_W-1:0]         count;
    logic                              empty;
    mts_pkg::err_e                     err;
  } stack_view_t;

  localparam int OP_TARGET   = 1900;  // no new run starts once this many ops are queued
  localparam int PACE_SPAN   = 150;   // ops per pacing phase
  localparam int HOLD_AT     = 700;   // transaction count that starts the long stall
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_WAIT  = 200;   // longer than the slowest transaction, a pop with a full rescan

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                              in_valid  = 1'b0;
  logic                              in_ready_o;
  mts_pkg::cmd_e                     op_drv    = mts_pkg::CMD_PUSH;
  logic signed [mts_pkg::DATA_W-1:0] value_drv = '0;
  logic                              out_valid_o;
  logic                              out_ready = 1'b0;
  logic signed [mts_pkg::DATA_W-1:0] top_value_o;
  logic signed [mts_pkg::DATA_W-1:0] min_value_o;
  logic [mts_pkg::CNT_W-1:0]         count_o;
  logic                              empty_res_o;
  logic [1:0]                        error_code_o;

  // Ops not yet offered, and views still owed by the block.
  stack_op_t   pending_ops[$];
  stack_view_t views_due[$];

  // Mirror of the stack contents, fill level and index of the minimum entry.
  logic signed [mts_pkg::DATA_W-1:0] mirror [mts_pkg::DEPTH];
  int fill    = 0;
  int low_idx = 0;

  // Statistics for the closing summary.
  int n_push_ok    = 0;
  int n_pop_ok     = 0;
  int n_full_drop  = 0;
  int n_empty_drop = 0;
  int n_rescan     = 0;
  int n_seen       = 0;
  int n_bad        = 0;

  int    n_taken   = 0;        // accepted input transactions
  pace_e pace_now  = PACE_STEADY;
  int    hold_left = 0;
  logic  hold_used = 1'b0;

  min_tracking_stack dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready_o),
    .cmd_i        (op_drv),
    .value_i      (value_drv),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready),
    .top_value_o  (top_value_o),
    .min_value_o  (min_value_o),
    .count_o      (count_o),
    .empty_res_o  (empty_res_o),
    .error_code_o (error_code_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Apply one op to the mirror and return the view the block must report.
  // Push: a strictly smaller value takes over the minimum; ties keep the old index.
  // Pop of the minimum entry: rescan from the bottom with strict less, so the
  // lowest index wins among equals. Full push / empty pop leave state alone.
  function automatic stack_view_t apply_op(mts_pkg::cmd_e op,
                                           logic signed [mts_pkg::DATA_W-1:0] v);
    stack_view_t r;
    r.err = mts_pkg::ERR_OK;
    if (op == mts_pkg::CMD_PUSH) begin
      if (fill == mts_pkg::DEPTH) begin
        r.err = mts_pkg::ERR_FULL;
        n_full_drop++;
      end else begin
        mirror[fill] = v;
        fill++;
        n_push_ok++;
        if (fill == 1 || v < mirror[low_idx]) low_idx = fill - 1;
      end
    end else if (fill == 0) begin
      r.err = mts_pkg::ERR_EMPTY;
      n_empty_drop++;
    end else begin
      fill--;
      n_pop_ok++;
      if (low_idx == fill) begin
        // minimum just left; an emptied stack parks the index at 0
        low_idx = 0;
        n_rescan++;
        for (int i = 1; i < fill; i++)
          if (mirror[i] < mirror[low_idx]) low_idx = i;
      end
    end
    if (fill == 0) begin
      r.top   = '0;
      r.low   = '0;
      r.empty = 1'b1;
    end else begin
      r.top   = mirror[fill-1];
      r.low   = mirror[low_idx];
      r.empty = 1'b0;
    end
    r.count = mts_pkg::CNT_W'(fill);
    return r;
  endfunction

  // Queue one op; the generator tracks its own fill level to shape runs.
  task automatic queue_op(input mts_pkg::cmd_e op,
                          input logic signed [mts_pkg::DATA_W-1:0] v,
                          inout int gen_fill, inout int n_gen);
    stack_op_t item;
    item.op   = op;
    item.val  = v;
    item.pace = pace_e'((n_gen / PACE_SPAN) % 4);
    pending_ops.push_back(item);
    n_gen++;
    if (op == mts_pkg::CMD_PUSH && gen_fill < mts_pkg::DEPTH) gen_fill++;
    if (op == mts_pkg::CMD_POP && gen_fill > 0) gen_fill--;
  endtask

  // Small values give plenty of ties; extremes and full-range values cover the bits.
  function automatic logic signed [mts_pkg::DATA_W-1:0] pick_value();
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(3))
          0:       return 32'h7FFFFFFF;
          1:       return 32'h80000000;
          2:       return '0;
          default: return '1;
        endcase
      end
      1, 2, 3, 4: return int'($urandom_range(16)) - 8;
      default:    return $urandom;
    endcase
  endfunction

  // Driver: offers the queued ops; a transaction is predicted on the edge it
  // is accepted. Valid holds with a stable payload until then.
  always @(posedge clk_i) begin : drive
    stack_op_t nxt;
    logic      rest;
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready_o) begin
        views_due.push_back(apply_op(op_drv, value_drv));
        n_taken <= n_taken + 1;
      end
      if (!in_valid || in_ready_o) begin
        rest = 1'b0;
        if (pending_ops.size() != 0) begin
          case (pending_ops[0].pace)
            PACE_SEND_GAPS: rest = ($urandom_range(99) < 46);
            PACE_BOTH_GAPS: rest = ($urandom_range(99) < 17);
            default:        rest = 1'b0;
          endcase
        end
        if (pending_ops.size() != 0 && !rest) begin
          nxt = pending_ops.pop_front();
          in_valid  <= 1'b1;
          op_drv    <= nxt.op;
          value_drv <= nxt.val;
          pace_now  <= nxt.pace;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off: once, mid-run, the receiver refuses results for
  // HOLD_CYCLES while the sender keeps offering, so the block backs up and
  // drops in_ready_o.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      hold_left <= 0;
    end else if (!hold_used && n_taken >= HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_used <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Receiver ready, paced by the phase of the op most recently driven.
  always @(posedge clk_i) begin : accept
    logic stall;
    case (pace_now)
      PACE_RECV_STALLS: stall = ($urandom_range(99) < 46);
      PACE_BOTH_GAPS:   stall = ($urandom_range(99) < 17);
      default:          stall = 1'b0;
    endcase
    if (!rst_ni) out_ready <= 1'b0;
    else         out_ready <= (hold_left == 0) && !stall;
  end

  // Monitor: every result transaction is checked against the oldest view owed.
  always @(posedge clk_i) begin : check
    stack_view_t want;
    if (rst_ni && out_valid_o && out_ready) begin
      n_seen++;
      if (views_due.size() == 0) begin
        $error("unexpected result: top %0d min %0d count %0d", top_value_o, min_value_o,
               count_o);
        n_bad++;
      end else begin
        want = views_due.pop_front();
        if (top_value_o !== want.top) begin
          $error("top_value: expected %0d, got %0d", want.top, top_value_o);
          n_bad++;
        end
        if (min_value_o !== want.low) begin
          $error("min_value: expected %0d, got %0d", want.low, min_value_o);
          n_bad++;
        end
        if (count_o !== want.count) begin
          $error("count: expected %0d, got %0d", want.count, count_o);
          n_bad++;
        end
        if (empty_res_o !== want.empty) begin
          $error("empty_res: expected %0d, got %0d", want.empty, empty_res_o);
          n_bad++;
        end
        if (error_code_o !== want.err) begin
          $error("error_code: expected %0d, got %0d", want.err, error_code_o);
          n_bad++;
        end
      end
    end
  end

  // Stimulus and end of run.
  initial begin : stimulus
    int gen_fill;
    int n_gen;
    int run;
    int extra;
    int len;

    gen_fill = 0;
    n_gen    = 0;

    // Directed: empty pop, extremes, tie on the minimum, popping down through
    // the minimum (with and without a rescan), emptying, bit patterns.
    queue_op(mts_pkg::CMD_POP,  0,            gen_fill, n_gen);  // pop on empty
    queue_op(mts_pkg::CMD_PUSH, 32'h7FFFFFFF, gen_fill, n_gen);  // most positive
    queue_op(mts_pkg::CMD_PUSH, 32'h80000000, gen_fill, n_gen);  // most negative
    queue_op(mts_pkg::CMD_PUSH, 32'h80000000, gen_fill, n_gen);  // tie: minimum stays
    queue_op(mts_pkg::CMD_PUSH, 0,            gen_fill, n_gen);
    queue_op(mts_pkg::CMD_POP,  32'hFFFFFFFF, gen_fill, n_gen);  // value ignored
    queue_op(mts_pkg::CMD_POP,  0,            gen_fill, n_gen);  // pops the tie
    queue_op(mts_pkg::CMD_POP,  0,            gen_fill, n_gen);  // minimum out, rescan
    queue_op(mts_pkg::CMD_POP,  0,            gen_fill, n_gen);  // empties
    queue_op(mts_pkg::CMD_POP,  0,            gen_fill, n_gen);  // pop on empty again
    queue_op(mts_pkg::CMD_PUSH, 32'h55555555, gen_fill, n_gen);
    queue_op(mts_pkg::CMD_PUSH, 32'hAAAAAAAA, gen_fill, n_gen);
    queue_op(mts_pkg::CMD_PUSH, 3,            gen_fill, n_gen);
    queue_op(mts_pkg::CMD_PUSH, 3,            gen_fill, n_gen);
    queue_op(mts_pkg::CMD_PUSH, -1,           gen_fill, n_gen);
    queue_op(mts_pkg::CMD_PUSH, 32'h80000001, gen_fill, n_gen);
    queue_op(mts_pkg::CMD_POP,  0,            gen_fill, n_gen);  // rescan: 0xAAAAAAAA
    queue_op(mts_pkg::CMD_POP,  0,            gen_fill, n_gen);
    queue_op(mts_pkg::CMD_POP,  0,            gen_fill, n_gen);
    queue_op(mts_pkg::CMD_POP,  0,            gen_fill, n_gen);
    queue_op(mts_pkg::CMD_POP,  0,            gen_fill, n_gen);  // minimum out, rescan
    queue_op(mts_pkg::CMD_POP,  0,            gen_fill, n_gen);  // back to empty

    // Random: mostly fill and drain runs so the full and empty corners are hit
    // repeatedly, plus balanced mixes and short noise bursts.
    run = 0;
    while (n_gen < OP_TARGET) begin
      case (run == 0 ? 0 : run == 1 ? 2 : $urandom_range(5))
        0, 1: begin
          extra = $urandom_range(1, 3);
          while (gen_fill < mts_pkg::DEPTH)
            queue_op(($urandom_range(9) == 0) ? mts_pkg::CMD_POP : mts_pkg::CMD_PUSH,
                     pick_value(), gen_fill, n_gen);
          repeat (extra) queue_op(mts_pkg::CMD_PUSH, pick_value(), gen_fill, n_gen);
        end
        2, 3: begin
          extra = $urandom_range(1, 2);
          while (gen_fill > 0)
            queue_op(($urandom_range(9) == 0) ? mts_pkg::CMD_PUSH : mts_pkg::CMD_POP,
                     pick_value(), gen_fill, n_gen);
          repeat (extra) queue_op(mts_pkg::CMD_POP, pick_value(), gen_fill, n_gen);
        end
        4: begin
          len = $urandom_range(20, 60);
          repeat (len)
            queue_op(mts_pkg::cmd_e'($urandom_range(1)), pick_value(), gen_fill, n_gen);
        end
        default: begin
          len = $urandom_range(3, 10);
          repeat (len)
            queue_op(mts_pkg::cmd_e'($urandom_range(1)), $urandom, gen_fill, n_gen);
        end
      endcase
      run++;
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_ops.size() != 0 || in_valid) @(posedge clk_i);
    while (views_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("covered %0d pushes (%0d refused on full), %0d pops (%0d refused on empty)",
             n_push_ok, n_full_drop, n_pop_ok, n_empty_drop);
    $display("%0d minimum rescans, %0d results checked, %0d mismatches",
             n_rescan, n_seen, n_bad);
    if (n_bad == 0) begin
      $display("min_tracking_stack_test OK");
    end else begin
      $display("min_tracking_stack_test NOT OK");
    end
    $finish;
  end

  // Watchdog: several times the slowest legal run.
  initial begin
    #25_000_000;
    $display("min_tracking_stack_test NOT OK");
    $finish;
  end

endmodule

`default_nettype wire
